// File: design/cext_pkg.sv
// ----------------------------------------------------------------------------
// cext_pkg: shared constants and helpers
// Fixed-point constants, CORDIC arctangent table and rounding helper for the
// clamped Euler X-Y-Z joint transform.
// ----------------------------------------------------------------------------
package cext_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned LaneStages  = CordicSteps + 3;   // clamp, fold, CORDIC, round
  localparam int unsigned MergeStages = 3;
  localparam int unsigned PipeStages  = LaneStages + MergeStages;

  localparam logic signed [19:0] PiQ16     = 20'sd205887;
  localparam logic signed [19:0] HalfPiQ16 = 20'sd102944;
  localparam logic signed [19:0] TwoPiQ16  = 20'sd411775;
  localparam logic signed [33:0] GainQ30   = 34'sd652032874;
  localparam logic signed [15:0] OneQ14    = 16'sd16384;

  localparam logic [4:0] ShiftCordic = 5'd16;
  localparam logic [4:0] ShiftTwo    = 5'd14;
  localparam logic [4:0] ShiftThree  = 5'd28;

  // configuration register indexes
  localparam logic [2:0] RegLimitsEn = 3'd0;
  localparam logic [2:0] RegMinX     = 3'd1;
  localparam logic [2:0] RegMaxX     = 3'd2;
  localparam logic [2:0] RegMinY     = 3'd3;
  localparam logic [2:0] RegMaxY     = 3'd4;
  localparam logic [2:0] RegMinZ     = 3'd5;
  localparam logic [2:0] RegMaxZ     = 3'd6;

  localparam logic [15:0] AtanQ16 [CordicSteps] = '{
    16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
    16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2
  };

  typedef struct packed {
    logic [2:0] lim_en;
    logic signed [15:0] lim_min;
    logic signed [15:0] lim_max;
  } axis_cfg_t;

  // round half away from zero by sh bits, then saturate to +/-1.0 in Q14
  function automatic logic signed [15:0] round_sat(input logic signed [47:0] v,
                                                   input logic [4:0] sh);
    logic        neg;
    logic [47:0] mag;
    logic [47:0] half;
    logic [47:0] q;
    logic [15:0] r;
    neg  = v[47];
    mag  = neg ? 48'(-v) : 48'(v);
    half = 48'd1 << (sh - 5'd1);
    q    = (mag + half) >> sh;
    r    = (q > 48'd16384) ? 16'd16384 : q[15:0];
    return neg ? 16'(-$signed(r)) : $signed(r);
  endfunction

endpackage

// File: design/clamped_euler_xyz_to_transform.sv
// ----------------------------------------------------------------------------
// clamped_euler_xyz_to_transform: Euler X-Y-Z joint transform
// Per-axis clamped angles to the 3x3 rotation part plus translation column.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o    angle_x/y/z, offset_x/y/z
//   out      output     out_valid_o / out_ready_i  m11..m33, trans_x/y/z
//   cfg      input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One word per cycle while the output is taken (out_ready_i high); stages: clamp, fold, 16 CORDIC stages,
// round, three matrix stages; the last is the output register.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// collapse and input is taken while a result waits at the output.
// Reset clears the valid bits and the configuration registers.
// ----------------------------------------------------------------------------
module clamped_euler_xyz_to_transform (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] angle_x_i,
  input  logic signed [15:0] angle_y_i,
  input  logic signed [15:0] angle_z_i,
  input  logic signed [15:0] offset_x_i,
  input  logic signed [15:0] offset_y_i,
  input  logic signed [15:0] offset_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] m11_o,
  output logic signed [15:0] m12_o,
  output logic signed [15:0] m13_o,
  output logic signed [15:0] m21_o,
  output logic signed [15:0] m22_o,
  output logic signed [15:0] m23_o,
  output logic signed [15:0] m31_o,
  output logic signed [15:0] m32_o,
  output logic signed [15:0] m33_o,
  output logic signed [15:0] trans_x_o,
  output logic signed [15:0] trans_y_o,
  output logic signed [15:0] trans_z_o
);

  localparam int unsigned P = cext_pkg::PipeStages;
  localparam int unsigned L = cext_pkg::LaneStages;

  // configuration
  logic               lim_en_q;
  logic signed [15:0] min_q [3];
  logic signed [15:0] max_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_en_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        min_q[k] <= -16'sd32768;
        max_q[k] <= 16'sd32767;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cext_pkg::RegLimitsEn: lim_en_q <= cfg_wdata_i[0];
        cext_pkg::RegMinX:     min_q[0] <= cfg_wdata_i;
        cext_pkg::RegMaxX:     max_q[0] <= cfg_wdata_i;
        cext_pkg::RegMinY:     min_q[1] <= cfg_wdata_i;
        cext_pkg::RegMaxY:     max_q[1] <= cfg_wdata_i;
        cext_pkg::RegMinZ:     min_q[2] <= cfg_wdata_i;
        cext_pkg::RegMaxZ:     max_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage valids and load chain
  logic [P-1:0] v_q, v_d, load;

  always_comb begin
    load[P-1] = ~v_q[P-1] | out_ready_i;
    for (int k = P - 2; k >= 0; k--) load[k] = ~v_q[k] | load[k+1];
    v_d[0] = load[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < P; k++) v_d[k] = load[k] ? v_q[k-1] : v_q[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else         v_q <= v_d;
  end

  assign in_ready_o  = load[0];
  assign out_valid_o = v_q[P-1];

  // offsets ride alongside
  logic [47:0] off_q [P];

  always_ff @(posedge clk_i) begin
    if (load[0]) off_q[0] <= {offset_x_i, offset_y_i, offset_z_i};
    for (int k = 1; k < P; k++) begin
      if (load[k]) off_q[k] <= off_q[k-1];
    end
  end

  // lanes
  logic signed [15:0] ang [3];
  logic signed [15:0] s [3];
  logic signed [15:0] c [3];
  cext_pkg::axis_cfg_t acfg [3];

  assign ang[0] = angle_x_i;
  assign ang[1] = angle_y_i;
  assign ang[2] = angle_z_i;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    assign acfg[g].lim_en  = 3'(g);
    assign acfg[g].lim_min = min_q[g];
    assign acfg[g].lim_max = max_q[g];
    cext_lane u_lane (
      .clk_i       (clk_i),
      .load_i      (load[L-1:0]),
      .limits_en_i (lim_en_q & (acfg[g].lim_en != 3'd7)),
      .cfg_i       (acfg[g]),
      .angle_i     (ang[g]),
      .sin_o       (s[g]),
      .cos_o       (c[g])
    );
  end

  logic signed [15:0] m [9];

  cext_merge u_merge (
    .clk_i  (clk_i),
    .load_i (load[P-1:L]),
    .sx_i   (s[0]),
    .cx_i   (c[0]),
    .sy_i   (s[1]),
    .cy_i   (c[1]),
    .sz_i   (s[2]),
    .cz_i   (c[2]),
    .m_o    (m)
  );

  assign m11_o = m[0];
  assign m12_o = m[1];
  assign m13_o = m[2];
  assign m21_o = m[3];
  assign m22_o = m[4];
  assign m23_o = m[5];
  assign m31_o = m[6];
  assign m32_o = m[7];
  assign m33_o = m[8];
  assign trans_x_o = off_q[P-1][47:32];
  assign trans_y_o = off_q[P-1][31:16];
  assign trans_z_o = off_q[P-1][15:0];

  // an accepted word always lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted word lost at pipe entry");

  // a new result only appears if the stage before held a word
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(v_q[P-2]))
    else $error("result without a source word");

  // first and last diagonal entries (m11, m33) stay within +/-1.0
  a_diag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (m11_o <= cext_pkg::OneQ14) && (m11_o >= -cext_pkg::OneQ14)
                 && (m33_o <= cext_pkg::OneQ14) && (m33_o >= -cext_pkg::OneQ14))
    else $error("matrix entry out of range");

endmodule

// File: design/cext_lane.sv
// ----------------------------------------------------------------------------
// cext_lane: one axis of sine/cosine
// Clamps the angle, reduces and folds it to +/-pi/2, runs an unrolled CORDIC
// pipeline and rounds the result to Q14.
// ----------------------------------------------------------------------------
module cext_lane (
  input  logic                                clk_i,
  input  logic [cext_pkg::LaneStages-1:0]     load_i,
  input  logic                                limits_en_i,
  input  cext_pkg::axis_cfg_t                 cfg_i,
  input  logic signed [15:0]                  angle_i,
  output logic signed [15:0]                  sin_o,
  output logic signed [15:0]                  cos_o
);

  localparam int unsigned N = cext_pkg::CordicSteps;

  logic signed [15:0] ang_q, ang_d;
  logic signed [19:0] fold_d;
  logic               neg_d;
  logic signed [33:0] x_q [N+1];
  logic signed [33:0] y_q [N+1];
  logic signed [19:0] z_q [N+1];
  logic               neg_q [N+1];
  logic signed [15:0] sin_q, cos_q;

  always_comb begin
    ang_d = angle_i;
    if (limits_en_i) begin
      if (ang_d < cfg_i.lim_min) ang_d = cfg_i.lim_min;
      if (ang_d > cfg_i.lim_max) ang_d = cfg_i.lim_max;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i[0]) ang_q <= ang_d;
  end

  // range reduction to +/-pi, then fold to +/-pi/2 with cosine sign flip
  always_comb begin
    logic signed [19:0] a;
    a = 20'(ang_q) <<< 3;
    if (a > cext_pkg::PiQ16) a = a - cext_pkg::TwoPiQ16;
    else if (a < -cext_pkg::PiQ16) a = a + cext_pkg::TwoPiQ16;
    neg_d  = 1'b0;
    fold_d = a;
    if (a > cext_pkg::HalfPiQ16) begin
      fold_d = cext_pkg::PiQ16 - a;
      neg_d  = 1'b1;
    end else if (a < -cext_pkg::HalfPiQ16) begin
      fold_d = -cext_pkg::PiQ16 - a;
      neg_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      x_q[0]   <= cext_pkg::GainQ30;
      y_q[0]   <= '0;
      z_q[0]   <= fold_d;
      neg_q[0] <= neg_d;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [19:0] at;
    assign at = $signed({4'd0, cext_pkg::AtanQ16[i]});
    always_ff @(posedge clk_i) begin
      if (load_i[i+2]) begin
        neg_q[i+1] <= neg_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + at;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i[N+2]) begin
      sin_q <= cext_pkg::round_sat(48'(y_q[N]), cext_pkg::ShiftCordic);
      cos_q <= neg_q[N]
             ? 16'(-cext_pkg::round_sat(48'(x_q[N]), cext_pkg::ShiftCordic))
             : cext_pkg::round_sat(48'(x_q[N]), cext_pkg::ShiftCordic);
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// File: design/cext_merge.sv
// ----------------------------------------------------------------------------
// cext_merge: matrix assembly
// Combines the three lanes' sines and cosines into the 3x3 rotation part:
// pair products, triple products, then rounding and saturation.
// ----------------------------------------------------------------------------
module cext_merge (
  input  logic                                  clk_i,
  input  logic [cext_pkg::MergeStages-1:0]      load_i,
  input  logic signed [15:0]                    sx_i,
  input  logic signed [15:0]                    cx_i,
  input  logic signed [15:0]                    sy_i,
  input  logic signed [15:0]                    cy_i,
  input  logic signed [15:0]                    sz_i,
  input  logic signed [15:0]                    cz_i,
  output logic signed [15:0]                    m_o [9]
);

  // stage 0: pair products, Q28
  logic signed [31:0] cycz_q, cysz_q, sxcy_q, cxcy_q, sxsy_q, cxsy_q;
  logic signed [31:0] cxsz_q, sxsz_q, cxcz_q, sxcz_q;
  logic signed [15:0] sy_q, cz_q, sz_q;

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      cycz_q <= 32'(cy_i) * 32'(cz_i);
      cysz_q <= 32'(cy_i) * 32'(sz_i);
      sxcy_q <= 32'(sx_i) * 32'(cy_i);
      cxcy_q <= 32'(cx_i) * 32'(cy_i);
      sxsy_q <= 32'(sx_i) * 32'(sy_i);
      cxsy_q <= 32'(cx_i) * 32'(sy_i);
      cxsz_q <= 32'(cx_i) * 32'(sz_i);
      sxsz_q <= 32'(sx_i) * 32'(sz_i);
      cxcz_q <= 32'(cx_i) * 32'(cz_i);
      sxcz_q <= 32'(sx_i) * 32'(cz_i);
      sy_q   <= sy_i;
      cz_q   <= cz_i;
      sz_q   <= sz_i;
    end
  end

  // stage 1: triple products, Q42
  logic signed [47:0] sxsycz_q, sxsysz_q, cxsycz_q, cxsysz_q;
  logic signed [31:0] cycz1_q, cysz1_q, sxcy1_q, cxcy1_q;
  logic signed [31:0] cxsz1_q, sxsz1_q, cxcz1_q, sxcz1_q;
  logic signed [15:0] sy1_q;

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      sxsycz_q <= 48'(sxsy_q) * 48'(cz_q);
      sxsysz_q <= 48'(sxsy_q) * 48'(sz_q);
      cxsycz_q <= 48'(cxsy_q) * 48'(cz_q);
      cxsysz_q <= 48'(cxsy_q) * 48'(sz_q);
      cycz1_q  <= cycz_q;
      cysz1_q  <= cysz_q;
      sxcy1_q  <= sxcy_q;
      cxcy1_q  <= cxcy_q;
      cxsz1_q  <= cxsz_q;
      sxsz1_q  <= sxsz_q;
      cxcz1_q  <= cxcz_q;
      sxcz1_q  <= sxcz_q;
      sy1_q    <= sy_q;
    end
  end

  // stage 2: at most one rounding per entry (m13 is the negated sine), into the output word
  logic signed [15:0] m_q [9];

  always_ff @(posedge clk_i) begin
    if (load_i[2]) begin
      m_q[0] <= cext_pkg::round_sat(48'(cycz1_q), cext_pkg::ShiftTwo);
      m_q[1] <= cext_pkg::round_sat(48'(cysz1_q), cext_pkg::ShiftTwo);
      m_q[2] <= 16'(-sy1_q);
      m_q[3] <= cext_pkg::round_sat(sxsycz_q - (48'(cxsz1_q) <<< 14), cext_pkg::ShiftThree);
      m_q[4] <= cext_pkg::round_sat(sxsysz_q + (48'(cxcz1_q) <<< 14), cext_pkg::ShiftThree);
      m_q[5] <= cext_pkg::round_sat(48'(sxcy1_q), cext_pkg::ShiftTwo);
      m_q[6] <= cext_pkg::round_sat(cxsycz_q + (48'(sxsz1_q) <<< 14), cext_pkg::ShiftThree);
      m_q[7] <= cext_pkg::round_sat(cxsysz_q - (48'(sxcz1_q) <<< 14), cext_pkg::ShiftThree);
      m_q[8] <= cext_pkg::round_sat(48'(cxcy1_q), cext_pkg::ShiftTwo);
    end
  end

  assign m_o = m_q;

endmodule
